// ----- hdl/wrrss_pkg.sv -----
// ============================================================================
// wrrss_pkg
// Shared widths, register indexes and lane types for the weighted
// round-robin skip selector.
// ============================================================================
package wrrss_pkg;

    // Build-time defaults for the top-level parameters
    localparam int MAX_TARGETS_DEF = 8;
    localparam int WEIGHT_BITS_DEF = 8;

    // Fixed field widths
    localparam int TRIED_W   = 8;   // tried_mask
    localparam int INDEX_W   = 3;   // target_index
    localparam int COUNT_W   = 4;   // target_count register
    localparam int TABLE_W   = 64;  // weight_table register
    localparam int CFG_IDX_W = 1;   // config register index

    // Config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_TABLE = 1'b1;

    // Per-lane status handed to the merge stage
    typedef struct packed {
        logic eligible;  // in use and not tried
        logic ahead;     // at or after the current position
    } t_lane_flags;

endpackage

// ----- hdl/wrrss_if.sv -----
// ============================================================================
// wrrss channel interfaces
// Valid/ready channels for requests, responses and config writes.
// ============================================================================
interface wrrss_req_if;
    logic                          valid;
    logic                          ready;
    logic [wrrss_pkg::TRIED_W-1:0] tried_mask;

    modport source (output valid, output tried_mask, input ready);
    modport sink   (input valid, input tried_mask, output ready);
endinterface

interface wrrss_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [wrrss_pkg::INDEX_W-1:0] target_index;
    logic                          found;

    modport source (output valid, output target_index, output found, input ready);
    modport sink   (input valid, input target_index, input found, output ready);
endinterface

interface wrrss_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [wrrss_pkg::CFG_IDX_W-1:0] index;
    logic [wrrss_pkg::TABLE_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hdl/weighted_round_robin_skip_selector.sv -----
// Response is registered: an accepted request beat loads the output register and shows on o_rsp in the next cycle.
// Throughput: 1 request per cycle while the output register is empty or drains; all target lanes and the rotating
//   priority find evaluate combinationally, output register decouples.
// Reset (i_rst_n low, synchronous): position, remaining weight, started
//   flag and output valid cleared; target_count = 1, weight_table = 0.
// ============================================================================
// weighted_round_robin_skip_selector
// Weighted round-robin selector that skips targets a request already tried.
// ============================================================================
module weighted_round_robin_skip_selector #(
    parameter int MAX_TARGETS = wrrss_pkg::MAX_TARGETS_DEF,
    parameter int WEIGHT_BITS = wrrss_pkg::WEIGHT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wrrss_req_if.sink   i_req,
    wrrss_rsp_if.source o_rsp,
    wrrss_cfg_if.sink   i_cfg
);
    import wrrss_pkg::*;

    localparam int POS_BITS = $clog2(MAX_TARGETS);
    localparam int CNT_BITS = $clog2(MAX_TARGETS + 1);
    localparam int RW_BITS  = WEIGHT_BITS + 1;

    // Config registers
    logic [COUNT_W-1:0] r_target_count;
    logic [TABLE_W-1:0] r_weight_table;

    // Arbitration state
    logic [POS_BITS-1:0] r_pos,  n_pos;
    logic [RW_BITS-1:0]  r_rw,   n_rw;
    logic                r_started;

    // Output register
    logic               r_out_valid;
    logic [INDEX_W-1:0] r_index, n_index;
    logic               r_found, n_found;

    logic                req_beat;
    logic [4:0]          cnt_w;
    logic [CNT_BITS-1:0] cnt;
    logic                restart;
    logic [POS_BITS-1:0] eff_pos;
    logic [RW_BITS-1:0]  eff_rw;
    logic [RW_BITS-1:0]  base_rw;
    logic [RW_BITS-1:0]  dec_rw;
    logic [CNT_BITS-1:0] sel_inc;
    logic [POS_BITS-1:0] sel_next;
    logic                hit;
    logic [POS_BITS-1:0] sel;

    t_lane_flags         lane_flags  [MAX_TARGETS];
    logic [RW_BITS-1:0]  lane_reload [MAX_TARGETS];

    // Handshakes: config always taken; a request goes in whenever the
    // output register is empty or drains this cycle.
    assign i_cfg.ready = 1'b1;
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign req_beat    = i_req.valid && i_req.ready;

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.target_index = r_index;
    assign o_rsp.found        = r_found;

    // Effective count: zero acts as one, clamp to the lane count
    always_comb begin
        if (r_target_count == '0) begin
            cnt_w = 5'd1;
        end else if ({1'b0, r_target_count} > 5'(MAX_TARGETS)) begin
            cnt_w = 5'(MAX_TARGETS);
        end else begin
            cnt_w = {1'b0, r_target_count};
        end
    end
    assign cnt = CNT_BITS'(cnt_w);

    // First request, or position stranded past a lowered count: restart at 0
    assign restart = !r_started || (CNT_BITS'(r_pos) >= cnt);
    assign eff_pos = restart ? '0 : r_pos;
    assign eff_rw  = restart ? lane_reload[0] : r_rw;

    // Per-target lanes
    generate
        for (genvar g = 0; g < MAX_TARGETS; g++) begin : g_lane
            wrrss_lane #(
                .LANE_IDX    (g),
                .WEIGHT_BITS (WEIGHT_BITS),
                .POS_BITS    (POS_BITS),
                .CNT_BITS    (CNT_BITS)
            ) u_lane (
                .i_tried_mask   (i_req.tried_mask),
                .i_count        (cnt),
                .i_pos          (eff_pos),
                .i_weight_table (r_weight_table),
                .o_flags        (lane_flags[g]),
                .o_reload       (lane_reload[g])
            );
        end
    endgenerate

    wrrss_merge #(
        .LANES    (MAX_TARGETS),
        .POS_BITS (POS_BITS)
    ) u_merge (
        .i_flags (lane_flags),
        .o_hit   (hit),
        .o_sel   (sel)
    );

    // Skipping onto a later target reloads its weight before the decrement
    assign base_rw  = (sel != eff_pos) ? lane_reload[sel] : eff_rw;
    assign dec_rw   = base_rw - RW_BITS'(1);
    assign sel_inc  = CNT_BITS'(sel) + CNT_BITS'(1);
    assign sel_next = (sel_inc == cnt) ? '0 : POS_BITS'(sel_inc);

    always_comb begin
        n_index = '0;
        n_found = 1'b0;
        if (!hit) begin
            // Full lap of skips: back at the start, weight reloaded
            n_pos = eff_pos;
            n_rw  = lane_reload[eff_pos];
        end else begin
            n_index = INDEX_W'(sel);
            n_found = 1'b1;
            if (dec_rw == '0) begin
                n_pos = sel_next;
                n_rw  = lane_reload[sel_next];
            end else begin
                n_pos = sel;
                n_rw  = dec_rw;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_count <= COUNT_W'(1);
            r_weight_table <= '0;
            r_pos          <= '0;
            r_rw           <= '0;
            r_started      <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (i_cfg.index)
                    CFG_TARGET_COUNT: r_target_count <= i_cfg.data[COUNT_W-1:0];
                    CFG_WEIGHT_TABLE: r_weight_table <= i_cfg.data;
                    default: ;
                endcase
            end
            if (req_beat) begin
                r_pos       <= n_pos;
                r_rw        <= n_rw;
                r_started   <= 1'b1;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Response payload, loaded per request beat
    always_ff @(posedge i_clk) begin
        if (req_beat) begin
            r_index <= n_index;
            r_found <= n_found;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_beat_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_beat |=> r_out_valid)
        else $error("request beat did not load the output register");

    a_started_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_started |=> r_started)
        else $error("started flag dropped outside reset");

    a_weight_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_started |-> (r_rw != '0))
        else $error("remaining weight is zero while running");

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_beat |=> (CNT_BITS'(r_pos) < $past(cnt)))
        else $error("position left past the target count");

    a_miss_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_found) |-> (r_index == '0))
        else $error("no target found but index nonzero");

endmodule

// ----- hdl/wrrss_lane.sv -----
// ============================================================================
// wrrss_lane
// One target lane: eligibility, wrap side and weight reload value.
// ============================================================================
module wrrss_lane #(
    parameter int LANE_IDX    = 0,
    parameter int WEIGHT_BITS = wrrss_pkg::WEIGHT_BITS_DEF,
    parameter int POS_BITS    = 3,
    parameter int CNT_BITS    = 4
) (
    input  logic [wrrss_pkg::TRIED_W-1:0] i_tried_mask,
    input  logic [CNT_BITS-1:0]           i_count,
    input  logic [POS_BITS-1:0]           i_pos,
    input  logic [wrrss_pkg::TABLE_W-1:0] i_weight_table,
    output wrrss_pkg::t_lane_flags        o_flags,
    output logic [WEIGHT_BITS:0]          o_reload
);
    import wrrss_pkg::*;

    localparam int LO = LANE_IDX * WEIGHT_BITS;

    logic tried;

    // Targets beyond the mask width are never tried
    generate
        if (LANE_IDX < TRIED_W) begin : g_mask
            assign tried = i_tried_mask[LANE_IDX];
        end else begin : g_nomask
            assign tried = 1'b0;
        end
    endgenerate

    assign o_flags.eligible = (CNT_BITS'(LANE_IDX) < i_count) && !tried;
    assign o_flags.ahead    = (POS_BITS'(LANE_IDX) >= i_pos);

    // Weights that fall past the table read as zero -> reload of one
    generate
        if (LO >= TABLE_W) begin : g_noweight
            assign o_reload = (WEIGHT_BITS+1)'(1);
        end else begin : g_weight
            logic [TABLE_W-1:0] shifted;
            assign shifted  = i_weight_table >> LO;
            assign o_reload = {1'b0, shifted[WEIGHT_BITS-1:0]} + (WEIGHT_BITS+1)'(1);
        end
    endgenerate

endmodule

// ----- hdl/wrrss_merge.sv -----
// ============================================================================
// wrrss_merge
// Rotating priority find over the lane flags.
// ============================================================================
module wrrss_merge #(
    parameter int LANES    = wrrss_pkg::MAX_TARGETS_DEF,
    parameter int POS_BITS = 3
) (
    input  wrrss_pkg::t_lane_flags i_flags [LANES],
    output logic                   o_hit,
    output logic [POS_BITS-1:0]    o_sel
);
    import wrrss_pkg::*;

    logic                hit_ahead;
    logic                hit_any;
    logic [POS_BITS-1:0] sel_ahead;
    logic [POS_BITS-1:0] sel_any;

    // Lowest eligible lane at/after the position, else lowest overall (wrap)
    always_comb begin
        hit_ahead = 1'b0;
        hit_any   = 1'b0;
        sel_ahead = '0;
        sel_any   = '0;
        for (int i = LANES - 1; i >= 0; i--) begin
            if (i_flags[i].eligible && i_flags[i].ahead) begin
                hit_ahead = 1'b1;
                sel_ahead = POS_BITS'(i);
            end
            if (i_flags[i].eligible) begin
                hit_any = 1'b1;
                sel_any = POS_BITS'(i);
            end
        end
    end

    assign o_hit = hit_any;
    assign o_sel = hit_ahead ? sel_ahead : sel_any;

endmodule
